// ----- hdl/bmp_pkg.sv -----
// ----------------------------------------------------------------------------
// bmp_pkg: shared types, constants and size helpers
// Geometry record, register indexes and effective-size functions for the
// block mean pixelizer.
// ----------------------------------------------------------------------------
`default_nettype none

package bmp_pkg;

    // defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_BLOCK_DEF = 64;

    // fixed field widths
    localparam int GEO_W    = 13;   // plane size registers
    localparam int BLK_W    = 7;    // block size registers
    localparam int PIX_W    = 8;    // sample width
    localparam int IDX_W    = 12;   // block index outputs
    localparam int PY_W     = 12;   // line counter, plane height is capped at 4096
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    localparam logic [15:0] EVEN_MASK    = 16'hFFFE;
    localparam logic [13:0] HEIGHT_LIMIT = 14'd4096;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LUMA_WIDTH   = 3'd0,
        CFG_LUMA_HEIGHT  = 3'd1,
        CFG_BLOCK_WIDTH  = 3'd2,
        CFG_BLOCK_HEIGHT = 3'd3,
        CFG_PLANE_CHROMA = 3'd4
    } t_cfg_idx;

    // effective plane and block sizes
    typedef struct packed {
        logic [GEO_W-1:0] w;
        logic [GEO_W-1:0] h;
        logic [BLK_W-1:0] bw;
        logic [BLK_W-1:0] bh;
    } t_geom;

    // plane size: halved for chroma, at least 1, at most limit
    function automatic logic [GEO_W-1:0] f_plane_size(
        input logic [GEO_W-1:0] luma,
        input logic             chroma,
        input logic [GEO_W:0]   limit
    );
        logic [GEO_W-1:0] s;
        s = chroma ? {1'b0, luma[GEO_W-1:1]} : luma;
        if (s == '0) s = GEO_W'(1);
        if ({1'b0, s} > limit) s = limit[GEO_W-1:0];
        return s;
    endfunction

    // block size: forced even, halved for chroma, at least 1, at most limit
    function automatic logic [BLK_W-1:0] f_block_size(
        input logic [BLK_W-1:0] req,
        input logic             chroma,
        input logic [8:0]       limit
    );
        logic [BLK_W-1:0] b;
        b = req & EVEN_MASK[BLK_W-1:0];
        if (chroma) b = {1'b0, b[BLK_W-1:1]};
        if (b == '0) b = BLK_W'(1);
        if (9'(b) > limit) b = limit[BLK_W-1:0];
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/bmp_cfg.sv -----
// ----------------------------------------------------------------------------
// bmp_cfg: configuration registers
// Holds the four size registers and the chroma flag, derives the effective
// geometry and flags a plane restart on every write to a known register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_cfg
    import bmp_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_geom                     o_geom,
    output logic                      o_restart
);

    localparam logic [GEO_W:0] WIDTH_LIMIT = (GEO_W+1)'(MAX_WIDTH);
    localparam logic [8:0]     BLOCK_LIMIT = 9'(MAX_BLOCK);

    logic [GEO_W-1:0] r_luma_w;
    logic [GEO_W-1:0] r_luma_h;
    logic [BLK_W-1:0] r_blk_w;
    logic [BLK_W-1:0] r_blk_h;
    logic             r_chroma;
    logic             n_known;

    // decode of the register index
    always_comb begin
        unique case (t_cfg_idx'(i_cfg_index))
            CFG_LUMA_WIDTH, CFG_LUMA_HEIGHT, CFG_BLOCK_WIDTH,
            CFG_BLOCK_HEIGHT, CFG_PLANE_CHROMA: n_known = 1'b1;
            default:                             n_known = 1'b0;
        endcase
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_luma_w <= GEO_W'(1920);
            r_luma_h <= GEO_W'(1080);
            r_blk_w  <= BLK_W'(2);
            r_blk_h  <= BLK_W'(2);
            r_chroma <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LUMA_WIDTH:   r_luma_w <= i_cfg_data[GEO_W-1:0];
                CFG_LUMA_HEIGHT:  r_luma_h <= i_cfg_data[GEO_W-1:0];
                CFG_BLOCK_WIDTH:  r_blk_w  <= i_cfg_data[BLK_W-1:0];
                CFG_BLOCK_HEIGHT: r_blk_h  <= i_cfg_data[BLK_W-1:0];
                CFG_PLANE_CHROMA: r_chroma <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_restart = i_cfg_wr_en && n_known;

    // effective geometry
    always_comb begin
        o_geom.w  = f_plane_size(r_luma_w, r_chroma, WIDTH_LIMIT);
        o_geom.h  = f_plane_size(r_luma_h, r_chroma, HEIGHT_LIMIT);
        o_geom.bw = f_block_size(r_blk_w, r_chroma, BLOCK_LIMIT);
        o_geom.bh = f_block_size(r_blk_h, r_chroma, BLOCK_LIMIT);
    end

endmodule

`default_nettype wire

// ----- hdl/bmp_accum.sv -----
// ----------------------------------------------------------------------------
// bmp_accum: raster counters and column sum memory
// Tracks the sample position, reads the block column's running sum,
// adds the sample and writes it back in the following cycle. Hands each finished
// block's sum and sample count to the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_accum
    import bmp_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  t_geom                         i_geom,
    input  wire logic                     i_restart,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [PIX_W-1:0]         i_pixel,
    input  wire logic                     i_div_idle,
    output logic                          o_job_valid,
    output logic [PIX_W+2*($clog2(MAX_BLOCK)+1)-1:0] o_job_sum,
    output logic [2*($clog2(MAX_BLOCK)+1)-1:0]       o_job_cnt,
    output logic [IDX_W-1:0]              o_job_col,
    output logic [IDX_W-1:0]              o_job_row,
    output logic                          o_job_last
);

    localparam int PX_W  = $clog2(MAX_WIDTH);
    localparam int XB_W  = $clog2(MAX_BLOCK);
    localparam int CNT_W = 2 * (XB_W + 1);
    localparam int SUM_W = PIX_W + CNT_W;
    localparam int CX_W  = (PX_W + 1 > GEO_W) ? PX_W + 1 : GEO_W;
    localparam int CY_W  = PY_W + 1;
    localparam int CB_W  = (XB_W + 1 > BLK_W) ? XB_W + 1 : BLK_W;

    // position counters
    logic [PX_W-1:0]  r_px;
    logic [PY_W-1:0]  r_py;
    logic [XB_W-1:0]  r_xib;
    logic [XB_W-1:0]  r_yib;
    logic [PX_W-1:0]  r_bix;
    logic [PY_W-1:0]  r_band;

    // column sum memory and read port
    logic [SUM_W-1:0] r_mem [MAX_WIDTH];
    logic [SUM_W-1:0] r_rd;
    logic             r_fwd;
    logic [SUM_W-1:0] r_fwd_data;

    // second stage
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_px;
    logic [PX_W-1:0]  r_s1_col;
    logic [PY_W-1:0]  r_s1_row;
    logic             r_s1_first;
    logic             r_s1_end;
    logic             r_s1_last;
    logic [CNT_W-1:0] r_s1_cnt;

    logic             last_col;
    logic             last_row;
    logic             x_wrap;
    logic             y_wrap;
    logic             blk_end;
    logic             first;
    logic             acc;
    logic [XB_W:0]    xc;
    logic [XB_W:0]    yc;
    logic [SUM_W-1:0] op;
    logic [SUM_W-1:0] s1_sum;

    // position decode
    always_comb begin
        xc       = {1'b0, r_xib} + (XB_W+1)'(1);
        yc       = {1'b0, r_yib} + (XB_W+1)'(1);
        last_col = (CX_W'(r_px) + CX_W'(1)) >= CX_W'(i_geom.w);
        last_row = (CY_W'(r_py) + CY_W'(1)) >= CY_W'(i_geom.h);
        x_wrap   = CB_W'(xc) >= CB_W'(i_geom.bw);
        y_wrap   = CB_W'(yc) >= CB_W'(i_geom.bh);
        blk_end  = (last_col || x_wrap) && (last_row || y_wrap);
        first    = (r_xib == '0) && (r_yib == '0);
    end

    // a block-ending item waits until the divider is sure to be free
    assign o_stall = blk_end && ((r_s1_valid && r_s1_end) || !i_div_idle);
    assign acc     = i_valid && !o_stall;

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_px       <= '0;
            r_py       <= '0;
            r_xib      <= '0;
            r_yib      <= '0;
            r_bix      <= '0;
            r_band     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc;
            if (acc) begin
                if (last_col) begin
                    r_px  <= '0;
                    r_xib <= '0;
                    r_bix <= '0;
                    if (last_row) begin
                        r_py   <= '0;
                        r_yib  <= '0;
                        r_band <= '0;
                    end else begin
                        r_py <= r_py + PY_W'(1);
                        if (y_wrap) begin
                            r_yib  <= '0;
                            r_band <= r_band + PY_W'(1);
                        end else begin
                            r_yib <= yc[XB_W-1:0];
                        end
                    end
                end else begin
                    r_px <= r_px + PX_W'(1);
                    if (x_wrap) begin
                        r_xib <= '0;
                        r_bix <= r_bix + PX_W'(1);
                    end else begin
                        r_xib <= xc[XB_W-1:0];
                    end
                end
            end
        end
    end

    // stage payload and forwarding of the write that lands with this read
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_px    <= i_pixel;
            r_s1_col   <= r_bix;
            r_s1_row   <= r_band;
            r_s1_first <= first;
            r_s1_end   <= blk_end;
            r_s1_last  <= last_col && last_row;
            r_s1_cnt   <= CNT_W'(xc) * CNT_W'(yc);
            r_fwd      <= r_s1_valid && (r_s1_col == r_bix);
            r_fwd_data <= s1_sum;
        end
    end

    // read-modify-write of the column sum
    always_comb begin
        op     = r_fwd ? r_fwd_data : r_rd;
        s1_sum = (r_s1_first ? '0 : op) + SUM_W'(r_s1_px);
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_rd <= r_mem[r_bix];
        if (r_s1_valid) r_mem[r_s1_col] <= s1_sum;
    end

    // job to the divider
    assign o_job_valid = r_s1_valid && r_s1_end;
    assign o_job_sum   = s1_sum;
    assign o_job_cnt   = r_s1_cnt;
    assign o_job_col   = IDX_W'(r_s1_col);
    assign o_job_row   = r_s1_row;
    assign o_job_last  = r_s1_last;

endmodule

`default_nettype wire

// ----- hdl/bmp_div.sv -----
// ----------------------------------------------------------------------------
// bmp_div: rounding mean divider and output register
// Adds half the count, then finds the 8-bit quotient one bit per cycle by
// restoring division. The result sits in an output register so the next
// division can run while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_div
    import bmp_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_job_valid,
    input  wire logic [PIX_W+2*($clog2(MAX_BLOCK)+1)-1:0] i_job_sum,
    input  wire logic [2*($clog2(MAX_BLOCK)+1)-1:0]       i_job_cnt,
    input  wire logic [IDX_W-1:0]        i_job_col,
    input  wire logic [IDX_W-1:0]        i_job_row,
    input  wire logic                    i_job_last,
    output logic                         o_idle,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [PIX_W-1:0]             o_block_mean,
    output logic [IDX_W-1:0]             o_block_column,
    output logic [IDX_W-1:0]             o_block_row,
    output logic                         o_frame_done
);

    localparam int CNT_W  = 2 * ($clog2(MAX_BLOCK) + 1);
    localparam int SUM_W  = PIX_W + CNT_W;
    localparam int REM_W  = SUM_W + 1;
    localparam int STEP_W = $clog2(PIX_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state            r_state;
    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  r_dsh;
    logic [CNT_W-1:0]  r_den;
    logic [PIX_W-1:0]  r_q;
    logic [STEP_W-1:0] r_step;
    logic [IDX_W-1:0]  r_col;
    logic [IDX_W-1:0]  r_row;
    logic              r_last;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_mean;
    logic [IDX_W-1:0]  r_out_col;
    logic [IDX_W-1:0]  r_out_row;
    logic              r_out_last;
    logic              q_bit;
    logic              out_free;

    assign q_bit    = r_rem >= r_dsh;
    assign out_free = !r_out_valid || !i_stall;

    // sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // filled from the done state, held while stalled
            r_out_valid <= ((r_state == ST_DONE) && out_free) || (r_out_valid && i_stall);
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_rem   <= REM_W'(i_job_sum);
                        r_den   <= i_job_cnt;
                        r_col   <= i_job_col;
                        r_row   <= i_job_row;
                        r_last  <= i_job_last;
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    // round half up, and line the divisor up with the top bit
                    r_rem   <= r_rem + REM_W'(r_den >> 1);
                    r_dsh   <= REM_W'(r_den) << (PIX_W - 1);
                    r_step  <= STEP_W'(PIX_W - 1);
                    r_q     <= '0;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (q_bit) r_rem <= r_rem - r_dsh;
                    r_q   <= {r_q[PIX_W-2:0], q_bit};
                    r_dsh <= r_dsh >> 1;
                    r_step <= r_step - STEP_W'(1);
                    if (r_step == '0) r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_mean  <= r_q;
                        r_out_col   <= r_col;
                        r_out_row   <= r_row;
                        r_out_last  <= r_last;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_idle         = (r_state == ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_block_mean   = r_out_mean;
    assign o_block_column = r_out_col;
    assign o_block_row    = r_out_row;
    assign o_frame_done   = r_out_last;

endmodule

`default_nettype wire

// ----- hdl/block_mean_pixelizer_unit.sv -----
// ----------------------------------------------------------------------------
// block_mean_pixelizer_unit: mosaic block averaging of one 8-bit plane
// A block's sum leaves the second accumulator stage, runs through the divider's
// round, run and done states and waits in the output register.
// Throughput: one sample per cycle; a block's last sample is held off until
// the divider has handed on the previous mean.
// Reset restores the register defaults and zeroes all position counters; the
// column sum memory is not cleared, each entry is written at its block's first
// sample. A write to a known register restarts the plane.
// ----------------------------------------------------------------------------
`default_nettype none

module block_mean_pixelizer_unit
    import bmp_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [PIX_W-1:0]     i_pixel,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [PIX_W-1:0]          o_block_mean,
    output logic [IDX_W-1:0]          o_block_column,
    output logic [IDX_W-1:0]          o_block_row,
    output logic                      o_frame_done
);

    localparam int CNT_W = 2 * ($clog2(MAX_BLOCK) + 1);
    localparam int SUM_W = PIX_W + CNT_W;

    t_geom             geom;
    logic              restart;
    logic              div_idle;
    logic              job_valid;
    logic [SUM_W-1:0]  job_sum;
    logic [CNT_W-1:0]  job_cnt;
    logic [IDX_W-1:0]  job_col;
    logic [IDX_W-1:0]  job_row;
    logic              job_last;

    bmp_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom),
        .o_restart   (restart)
    );

    bmp_accum #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_restart   (restart),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel     (i_pixel),
        .i_div_idle  (div_idle),
        .o_job_valid (job_valid),
        .o_job_sum   (job_sum),
        .o_job_cnt   (job_cnt),
        .o_job_col   (job_col),
        .o_job_row   (job_row),
        .o_job_last  (job_last)
    );

    bmp_div #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (job_valid),
        .i_job_sum      (job_sum),
        .i_job_cnt      (job_cnt),
        .i_job_col      (job_col),
        .i_job_row      (job_row),
        .i_job_last     (job_last),
        .o_idle         (div_idle),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_block_mean   (o_block_mean),
        .o_block_column (o_block_column),
        .o_block_row    (o_block_row),
        .o_frame_done   (o_frame_done)
    );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for block_mean_pixelizer_unit
// Streams 8-bit planes through the pixelizer under many plane and block
// geometries. A scoreboard predicts every block mean and position from the
// same register settings and compares each result that leaves the block.
// ----------------------------------------------------------------------------

module tb_top
    import bmp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int DRAIN_CYCLES  = 30;     // settle time after the last expected mean
    localparam int STALL_LIMIT   = 4000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
    localparam int RANDOM_PIXELS = 800;
    localparam int PHASE_CAP     = 200;
    localparam int MAX_REPORTS   = 10;
    localparam int HEIGHT_CAP    = 4096;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_IDX_W'(CFG_PLANE_CHROMA) + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;

    localparam logic [PIX_W-1:0] BIT_TOGGLE_PX [4] = '{8'h00, 8'hFF, 8'h55, 8'hAA};
    // 2x2 blocks: first sums to 2 (exact half rounds up), second to 1018
    localparam logic [PIX_W-1:0] ROUNDING_PX [8] =
        '{8'd0, 8'd1, 8'd255, 8'd254, 8'd1, 8'd0, 8'd255, 8'd254};
    localparam logic [PIX_W-1:0] TINY_PLANE_PX [3] = '{8'd128, 8'd0, 8'd255};

    typedef enum {MIX_ANY, MIX_HIGH} t_pixel_mix;

    typedef struct packed {
        logic [PIX_W-1:0] mean;
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
        logic             frame_done;
    } t_block_result;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks plane position and column sums, queues block means
    // ------------------------------------------------------------------------
    class t_mosaic_scoreboard;
        logic [GEO_W-1:0] luma_w, luma_h;
        logic [BLK_W-1:0] blk_w_req, blk_h_req;
        logic             chroma;
        int unsigned      col_sum [MAX_WIDTH_DEF];
        int unsigned      pos_x, pos_y, in_blk_x, in_blk_y, blk_col, band;
        t_block_result    due_blocks [$];
        int unsigned      failures, reports, pixels_taken, blocks_checked, reg_writes;

        function new();
            luma_w    = 13'd1920;
            luma_h    = 13'd1080;
            blk_w_req = 7'd2;
            blk_h_req = 7'd2;
            chroma    = 1'b0;
            restart();
        endfunction

        function void restart();
            pos_x    = 0;
            pos_y    = 0;
            in_blk_x = 0;
            in_blk_y = 0;
            blk_col  = 0;
            band     = 0;
        endfunction

        // halved for chroma, then clamped to [1, limit]
        function int unsigned plane_dim(input logic [GEO_W-1:0] luma, input int unsigned limit);
            int unsigned s;
            s = 32'(chroma ? (luma >> 1) : luma);
            if (s < 1) s = 1;
            if (s > limit) s = limit;
            return s;
        endfunction

        // forced even, halved for chroma, then clamped to [1, MAX_BLOCK]
        function int unsigned block_dim(input logic [BLK_W-1:0] req);
            int unsigned b;
            b = 32'(req & EVEN_MASK[BLK_W-1:0]);
            if (chroma) b = b >> 1;
            if (b < 1) b = 1;
            if (b > MAX_BLOCK_DEF) b = MAX_BLOCK_DEF;
            return b;
        endfunction

        function int unsigned plane_pixels();
            return plane_dim(luma_w, MAX_WIDTH_DEF) * plane_dim(luma_h, HEIGHT_CAP);
        endfunction

        function int pending();
            return due_blocks.size();
        endfunction

        // known registers restart the plane, others are dropped
        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
            reg_writes++;
            case (idx)
                CFG_LUMA_WIDTH:   luma_w    = data[GEO_W-1:0];
                CFG_LUMA_HEIGHT:  luma_h    = data[GEO_W-1:0];
                CFG_BLOCK_WIDTH:  blk_w_req = data[BLK_W-1:0];
                CFG_BLOCK_HEIGHT: blk_h_req = data[BLK_W-1:0];
                CFG_PLANE_CHROMA: chroma    = data[0];
                default:          return;
            endcase
            restart();
        endfunction

        // accumulate one sample, queue the mean when it closes a block
        function void take_pixel(input logic [PIX_W-1:0] pix);
            int unsigned   w, h, bw, bh, col, cnt;
            bit            last_col, last_row, end_x, end_y;
            t_block_result r;
            w        = plane_dim(luma_w, MAX_WIDTH_DEF);
            h        = plane_dim(luma_h, HEIGHT_CAP);
            bw       = block_dim(blk_w_req);
            bh       = block_dim(blk_h_req);
            col      = blk_col % MAX_WIDTH_DEF;
            last_col = (pos_x + 1 >= w);
            last_row = (pos_y + 1 >= h);
            end_x    = last_col || (in_blk_x + 1 >= bw);
            end_y    = last_row || (in_blk_y + 1 >= bh);
            pixels_taken++;

            if (in_blk_x == 0 && in_blk_y == 0) col_sum[col] = 32'(pix);
            else col_sum[col] += 32'(pix);

            if (end_x && end_y) begin
                cnt          = (in_blk_x + 1) * (in_blk_y + 1);
                r.mean       = PIX_W'((col_sum[col] + (cnt >> 1)) / cnt);
                r.column     = IDX_W'(blk_col);
                r.row        = IDX_W'(band);
                r.frame_done = last_col && last_row;
                due_blocks.push_back(r);
            end

            // advance raster position
            if (last_col) begin
                pos_x    = 0;
                in_blk_x = 0;
                blk_col  = 0;
                if (last_row) begin
                    pos_y    = 0;
                    in_blk_y = 0;
                    band     = 0;
                end else begin
                    pos_y++;
                    if (in_blk_y + 1 >= bh) begin
                        in_blk_y = 0;
                        band++;
                    end else begin
                        in_blk_y++;
                    end
                end
            end else begin
                pos_x++;
                if (in_blk_x + 1 >= bw) begin
                    in_blk_x = 0;
                    blk_col++;
                end else begin
                    in_blk_x++;
                end
            end
        endfunction

        function void check_block(input t_block_result got);
            t_block_result want;
            if (due_blocks.size() == 0) begin
                failures++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("unexpected block: mean %0d column %0d row %0d done %0b",
                             got.mean, got.column, got.row, got.frame_done);
                end
                return;
            end
            want = due_blocks.pop_front();
            blocks_checked++;
            if (got.mean !== want.mean || got.column !== want.column ||
                got.row !== want.row || got.frame_done !== want.frame_done) begin
                failures++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("block mismatch: expected mean %0d column %0d row %0d done %0b",
                             want.mean, want.column, want.row, want.frame_done);
                    $display("                got      mean %0d column %0d row %0d done %0b",
                             got.mean, got.column, got.row, got.frame_done);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and stimulus signals
    // ------------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic [PIX_W-1:0]     i_pixel     = '0;
    logic                 i_stall     = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [PIX_W-1:0]     o_block_mean;
    logic [IDX_W-1:0]     o_block_column;
    logic [IDX_W-1:0]     o_block_row;
    logic                 o_frame_done;

    t_mosaic_scoreboard sb;
    int idle_pct     = 14;
    int stall_pct    = 59;
    int hold_asks    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int random_sent  = 0;
    int phases_run   = 0;

    block_mean_pixelizer_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel        (i_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_block_mean   (o_block_mean),
        .o_block_column (o_block_column),
        .o_block_row    (o_block_row),
        .o_frame_done   (o_frame_done)
    );

    initial begin
        forever #(HALF_PERIOD) i_clk = ~i_clk;
    end

    // receiver: random stall, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result check and activity tracking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if (o_valid && !i_stall)
                sb.check_block(t_block_result'{o_block_mean, o_block_column,
                                               o_block_row, o_frame_done});
            if ((o_valid && !i_stall) || (i_valid && !o_stall) || i_cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // watchdog
    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("watchdog: nothing moved for %0d cycles, %0d block means outstanding",
                 quiet_cycles, sb.pending());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (o_stall);
        sb.take_pixel(pix);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // stop sending, wait for every mean, then let the divider settle
    task automatic quiesce();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // unused upper data bits are randomized, the block must mask them
    task automatic setup_plane(input logic [GEO_W-1:0] lw, input logic [GEO_W-1:0] lh,
                               input logic [BLK_W-1:0] bw, input logic [BLK_W-1:0] bh,
                               input logic chroma_pl);
        cfg_write(CFG_LUMA_WIDTH, lw);
        cfg_write(CFG_LUMA_HEIGHT, lh);
        cfg_write(CFG_BLOCK_WIDTH, {6'($urandom), bw});
        cfg_write(CFG_BLOCK_HEIGHT, {6'($urandom), bh});
        cfg_write(CFG_PLANE_CHROMA, {12'($urandom), chroma_pl});
        phases_run++;
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input t_pixel_mix mix);
        int r;
        r = $urandom_range(99);
        if (mix == MIX_HIGH) return PIX_W'($urandom_range(255, 242));
        if (r < 5) return '0;
        if (r < 10) return '1;
        return PIX_W'($urandom);
    endfunction

    // split: halfway, write an unused index; the plane must carry on
    task automatic stream_pixels(input int n, input t_pixel_mix mix, input bit split);
        for (int k = 0; k < n; k++) begin
            if (split && k == n / 2) begin
                quiesce();
                cfg_write(CFG_IDX_W'($urandom_range(CFG_LAST_UNUSED, CFG_FIRST_UNUSED)),
                          CFG_DAT_W'($urandom));
            end
            send_pixel(pick_pixel(mix));
        end
        quiesce();
    endtask

    function automatic logic [GEO_W-1:0] pick_luma(input int typical_hi);
        int r;
        r = $urandom_range(99);
        if (r < 8) return GEO_W'($urandom_range(1));             // zero plane after halving
        if (r < 16) return GEO_W'($urandom_range(4 * typical_hi, typical_hi + 1));
        return GEO_W'($urandom_range(typical_hi, 2));
    endfunction

    function automatic logic [BLK_W-1:0] pick_block();
        int r;
        r = $urandom_range(99);
        if (r < 10) return BLK_W'($urandom_range(127, 64));       // capped at max block
        if (r < 30) return BLK_W'($urandom_range(24, 10));
        return BLK_W'($urandom_range(9, 1));
    endfunction

    task automatic random_plane();
        logic [GEO_W-1:0] lw, lh;
        logic [BLK_W-1:0] bw, bh;
        logic             chroma_pl;
        int               plane, n;
        lw        = pick_luma(24);
        lh        = pick_luma(8);
        bw        = pick_block();
        bh        = pick_block();
        chroma_pl = 1'($urandom_range(1));
        setup_plane(lw, lh, bw, bh, chroma_pl);
        plane = sb.plane_pixels();
        n = plane * $urandom_range(2, 1) + $urandom_range(plane / 2);
        if (n > PHASE_CAP) n = PHASE_CAP;
        stream_pixels(n, MIX_ANY, $urandom_range(3) == 0);
        random_sent += n;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: first line of a 1920-wide plane, no block closes
        foreach (BIT_TOGGLE_PX[k]) send_pixel(BIT_TOGGLE_PX[k]);
        quiesce();

        // 4x2 plane, 2x2 blocks: half-up rounding and full-scale sum
        setup_plane(13'd4, 13'd2, 7'd2, 7'd2, 1'b0);
        foreach (ROUNDING_PX[k]) send_pixel(ROUNDING_PX[k]);
        quiesce();

        // chroma with zero plane and zero block sizes: every sample ends a plane
        setup_plane(13'd1, 13'd0, 7'd1, 7'd0, 1'b1);
        foreach (TINY_PLANE_PX[k]) send_pixel(TINY_PLANE_PX[k]);
        quiesce();

        // odd block requests forced even, partial blocks at right and bottom
        setup_plane(13'd3, 13'd3, 7'd3, 7'd3, 1'b0);
        stream_pixels(9, MIX_ANY, 1'b0);

        // oversized width: start of a single row capped at the maximum width
        setup_plane(13'h1FFF, 13'd1, 7'd2, 7'd2, 1'b0);
        stream_pixels(192, MIX_ANY, 1'b0);

        // oversized height: bands keep advancing
        setup_plane(13'd2, 13'h1FFF, 7'd2, 7'd2, 1'b0);
        stream_pixels(8, MIX_ANY, 1'b0);

        while (random_sent < RANDOM_PIXELS / 3) random_plane();

        idle_pct  = 59;
        stall_pct = 14;

        // 1x1 blocks under a long receiver hold-off: block backs up and stalls
        setup_plane(13'd16, 13'd8, 7'd1, 7'd1, 1'b0);
        hold_asks++;
        stream_pixels(128, MIX_ANY, 1'b0);

        // largest block with bright samples: big sums and partial right block
        setup_plane(13'd70, 13'd3, 7'd127, 7'd127, 1'b0);
        stream_pixels(70 * 3, MIX_HIGH, 1'b0);

        while (random_sent < 2 * RANDOM_PIXELS / 3) random_plane();

        idle_pct  = 0;
        stall_pct = 0;
        while (random_sent < RANDOM_PIXELS) random_plane();

        quiesce();
        $display("run covered %0d samples and %0d block means over %0d plane setups",
                 sb.pixels_taken, sb.blocks_checked, phases_run);
        $display("%0d register writes, luma and chroma planes, blocks 1x1 to 64x64, %0d errors",
                 sb.reg_writes, sb.failures);
        if (sb.failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
